>>> rtl/slst_pkg.sv
// shared types and constants for the segmented list store
package slst_pkg;

   // default sizes
   localparam int STORE_DEPTH_DEF   = 256;
   localparam int SEGMENT_COUNT_DEF = 16;

   // fixed field widths
   localparam int FUNC_W   = 1;
   localparam int SEG_W    = 4;
   localparam int IDX_W    = 8;
   localparam int SINK_W   = 16;
   localparam int HANDLE_W = 32;
   localparam int END_W    = 9;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = SINK_W + HANDLE_W;

   // stream data widths, whole bytes
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

   // update commands to the mark table
   typedef struct packed {
      logic set_end;   // write the target segment's end mark
      logic bump;      // raise marks of all later segments and the used length
   } mark_cmd_type;

endpackage

>>> rtl/slst_ram.sv
// generic ram, one write port and one registered read port
module slst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/slst_marks.sv
// segment start and end marks and the used length
module slst_marks import slst_pkg::*; #(
   parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
   parameter int MARK_W        = 9,
   parameter int SEG_IDX_W     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SEG_IDX_W-1:0] seg,
   input  mark_cmd_type         cmd,
   input  logic [MARK_W-1:0]    new_end,
   output logic [MARK_W-1:0]    seg_start,
   output logic [MARK_W-1:0]    seg_end,
   output logic [MARK_W-1:0]    seg_limit,
   output logic [MARK_W-1:0]    used
);

   logic [MARK_W-1:0]    starts_ff [SEGMENT_COUNT];
   logic [MARK_W-1:0]    ends_ff   [SEGMENT_COUNT];
   logic [MARK_W-1:0]    used_ff;
   logic [SEG_IDX_W-1:0] seg_next;
   logic                 seg_is_last;

   // lookups for the target segment
   assign seg_next    = seg + SEG_IDX_W'(1);
   assign seg_is_last = (32'(seg) == 32'(SEGMENT_COUNT - 1));
   assign seg_start   = starts_ff[seg];
   assign seg_end     = ends_ff[seg];
   assign seg_limit   = seg_is_last ? used_ff : starts_ff[seg_next];
   assign used        = used_ff;

   // per-segment updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SEGMENT_COUNT; k++) begin
            starts_ff[k] <= '0;
            ends_ff[k]   <= '0;
         end
         used_ff <= '0;
      end else begin
         for (int k = 0; k < SEGMENT_COUNT; k++) begin
            if (cmd.set_end && (32'(seg) == k)) begin
               ends_ff[k] <= new_end;
            end else if (cmd.bump && (k > 32'(seg))) begin
               ends_ff[k] <= ends_ff[k] + MARK_W'(1);
            end
            if (cmd.bump && (k > 32'(seg))) begin
               starts_ff[k] <= starts_ff[k] + MARK_W'(1);
            end
         end
         if (cmd.bump) begin
            used_ff <= used_ff + MARK_W'(1);
         end
      end
   end

endmodule

>>> rtl/segmented_list_store_core.sv
// segmented list store: entry ram, mark table and operation sequencer
// steps from acceptance: insert into slack, refused or bad item: evaluate, done; remove: evaluate,
// move last entry, clear, done; insert with shift: evaluate, read/write per moved entry, put, done;
// the result item becomes valid as the input reopens, and a result still waiting on the
// output register holds the sequencer; the shift loop over the single ram read port sets the rate
// reset: synchronous, clears all marks and the used length; entry ram is not cleared
module segmented_list_store_core import slst_pkg::*; #(
   parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
   parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // func, segment_id, slot_index, sink_id, watch_handle
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // segment_end, status
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int MARK_W    = $clog2(STORE_DEPTH + 1);
   localparam int SEG_IDX_W = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_RM_WR, S_RM_CLR, S_DONE
   } state_type;

   state_type             state_ff;
   logic [FUNC_W-1:0]     func_ff;
   logic [SEG_W-1:0]      seg_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [SINK_W-1:0]     sink_ff;
   logic [HANDLE_W-1:0]   handle_ff;
   logic [MARK_W-1:0]     k_ff;
   logic [MARK_W-1:0]     end_ff;
   logic [MARK_W-1:0]     res_end_ff;
   logic [STATUS_W-1:0]   res_status_ff;
   logic                  rsp_valid_ff;
   logic [END_W-1:0]      rsp_end_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]    rd_data;

   mark_cmd_type          cmd;
   logic [MARK_W-1:0]     new_end;
   logic [MARK_W-1:0]     seg_start;
   logic [MARK_W-1:0]     seg_end;
   logic [MARK_W-1:0]     seg_limit;
   logic [MARK_W-1:0]     used;
   logic [SEG_IDX_W-1:0]  seg_idx;

   logic                  req_fire;
   logic                  rsp_load;
   logic                  seg_ok;
   logic                  has_slack;
   logic                  cant_shift;
   logic                  rm_bad;
   logic [MARK_W-1:0]     last;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - END_W - STATUS_W){1'b0}}, rsp_status_ff, rsp_end_ff};
   assign seg_idx    = SEG_IDX_W'(seg_ff);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // decision terms for the evaluate step
   assign seg_ok     = (32'(seg_ff) < 32'(SEGMENT_COUNT));
   assign has_slack  = (seg_limit > seg_end) && (32'(seg_end) < 32'(STORE_DEPTH));
   assign cant_shift = (32'(used) >= 32'(STORE_DEPTH)) || (seg_end > used);
   assign rm_bad     = (seg_end <= seg_start) || (32'(idx_ff) < 32'(seg_start))
                     || (32'(idx_ff) >= 32'(seg_end)) || (32'(seg_end) > 32'(STORE_DEPTH));
   assign last       = seg_end - MARK_W'(1);

   slst_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   slst_marks #(
      .SEGMENT_COUNT (SEGMENT_COUNT),
      .MARK_W        (MARK_W),
      .SEG_IDX_W     (SEG_IDX_W)
   ) u_marks (
      .clock     (clock),
      .reset     (reset),
      .seg       (seg_idx),
      .cmd       (cmd),
      .new_end   (new_end),
      .seg_start (seg_start),
      .seg_end   (seg_end),
      .seg_limit (seg_limit),
      .used      (used)
   );

   // ram and mark table controls per state
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(end_ff);
      wr_data = {sink_ff, handle_ff};
      rd_addr = ADDR_W'(k_ff - MARK_W'(1));
      cmd     = '0;
      new_end = end_ff + MARK_W'(1);
      unique case (state_ff)
         S_EVAL: begin
            if (seg_ok && func_ff == FUNC_INSERT && has_slack) begin
               wr_en       = 1'b1;
               wr_addr     = ADDR_W'(seg_end);
               new_end     = seg_end + MARK_W'(1);
               cmd.set_end = 1'b1;
            end else if (seg_ok && func_ff == FUNC_REMOVE && !rm_bad) begin
               rd_addr     = ADDR_W'(last);
               new_end     = last;
               cmd.set_end = 1'b1;
            end
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(k_ff);
            wr_data = rd_data;
         end
         S_PUT: begin
            wr_en       = 1'b1;
            cmd.set_end = 1'b1;
            cmd.bump    = 1'b1;
         end
         S_RM_WR: begin
            wr_en   = (32'(idx_ff) != 32'(end_ff));
            wr_addr = ADDR_W'(idx_ff);
            wr_data = rd_data;
         end
         S_RM_CLR: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         default: begin
         end
      endcase
   end

   // sequencer, result register and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  func_ff   <= req_tdata[0];
                  seg_ff    <= req_tdata[4:1];
                  idx_ff    <= req_tdata[12:5];
                  sink_ff   <= req_tdata[28:13];
                  handle_ff <= req_tdata[60:29];
                  state_ff  <= S_EVAL;
               end
            end
            S_EVAL: begin
               end_ff <= seg_end;
               k_ff   <= used;
               if (!seg_ok) begin
                  res_end_ff    <= '0;
                  res_status_ff <= STATUS_BAD_INDEX;
                  state_ff      <= S_DONE;
               end else if (func_ff == FUNC_INSERT) begin
                  if (has_slack) begin
                     res_end_ff    <= seg_end + MARK_W'(1);
                     res_status_ff <= STATUS_OK;
                     state_ff      <= S_DONE;
                  end else if (cant_shift) begin
                     res_end_ff    <= seg_end;
                     res_status_ff <= STATUS_FULL;
                     state_ff      <= S_DONE;
                  end else if (used > seg_end) begin
                     state_ff <= S_SHIFT_RD;
                  end else begin
                     state_ff <= S_PUT;
                  end
               end else if (rm_bad) begin
                  res_end_ff    <= seg_end;
                  res_status_ff <= STATUS_BAD_INDEX;
                  state_ff      <= S_DONE;
               end else begin
                  end_ff   <= last;
                  state_ff <= S_RM_WR;
               end
            end
            S_SHIFT_RD: begin
               state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               k_ff     <= k_ff - MARK_W'(1);
               state_ff <= (k_ff - MARK_W'(1) > end_ff) ? S_SHIFT_RD : S_PUT;
            end
            S_PUT: begin
               res_end_ff    <= end_ff + MARK_W'(1);
               res_status_ff <= STATUS_OK;
               state_ff      <= S_DONE;
            end
            S_RM_WR: begin
               state_ff <= S_RM_CLR;
            end
            S_RM_CLR: begin
               res_end_ff    <= end_ff;
               res_status_ff <= STATUS_OK;
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_end_ff    <= END_W'(res_end_ff);
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // used length never passes the store depth
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used) <= 32'(STORE_DEPTH))
      else $error("used length beyond store depth");

   // shift loop only runs above the insertion point
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_RD || state_ff == S_SHIFT_WR) |-> (k_ff > end_ff))
      else $error("shift pointer at or below end mark");

   // no result code beyond bad index
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STATUS_OK || rsp_status_ff == STATUS_FULL
                        || rsp_status_ff == STATUS_BAD_INDEX))
      else $error("undefined status code");

   // one item in flight: an accepted item blocks the input next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second item taken while busy");

endmodule
